// ----- rtl/core/rsabc_pkg.sv -----
`timescale 1ns / 1ps
// Package for the byte-stream RSA cipher: defaults, register indexes, payload structs
// and the sequencer state type. Depends on nothing else.
package rsabc_pkg;

    localparam int MOD_WIDTH_DEF    = 16;
    localparam int CIPHER_BYTES_DEF = 4;
    localparam int CFG_WIDTH        = 16;
    localparam int CFG_IDX_WIDTH    = 2;

    localparam logic [CFG_IDX_WIDTH-1:0] CFG_MODULUS     = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_PUBLIC_EXP  = 2'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_PRIVATE_EXP = 2'd2;

    localparam logic FUNC_ENCRYPT = 1'b0;
    localparam logic FUNC_DECRYPT = 1'b1;

    typedef struct packed {
        logic       func;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_NEXT,
        ST_MUL_ACC,
        ST_MUL_SQ,
        ST_EMIT
    } seq_state_t;

endpackage

// ----- rtl/core/rsa_byte_cipher_modexp_top.sv -----
`timescale 1ns / 1ps
// Top level of the byte-stream RSA cipher: request channels, key registers and sequencer.
// Depends on rsabc_pkg and rsabc_modmul.

// Each request is handled alone; item_stall stays high until every result byte of it has
// been taken. Encryption raises the plaintext byte to e mod n and sends the value as
// CIPHER_BYTES bytes, most significant first; decryption gathers CIPHER_BYTES bytes and on
// the last one sends the low byte of C^d mod n. All arithmetic runs through one bit-serial
// modular multiplier that handles one operand bit per cycle: the operand is first reduced
// mod n in ST_REDUCE, and each exponent bit up to the highest set one passes through a
// decision in ST_NEXT, a square in ST_MUL_SQ and, when the bit is set, a multiply into the
// accumulator in ST_MUL_ACC before it, the square after the highest set bit being skipped;
// one further decision in ST_NEXT ends the exponent. Result bytes then leave one per cycle
// while result_stall is low. A decrypt byte that does not close a group is absorbed while
// the block stays idle. Key registers may be written only while no request is in progress;
// cfg_ready is always high.
module rsa_byte_cipher_modexp_top #(
    parameter int MOD_WIDTH    = rsabc_pkg::MOD_WIDTH_DEF,
    parameter int CIPHER_BYTES = rsabc_pkg::CIPHER_BYTES_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 item_valid,
    output logic                                 item_stall,
    input  rsabc_pkg::in_item_t                  item,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output rsabc_pkg::out_item_t                 result,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [rsabc_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
    input  logic [rsabc_pkg::CFG_WIDTH-1:0]      cfg_data
);
    import rsabc_pkg::*;

    localparam int XW  = 8 * CIPHER_BYTES;
    localparam int PW  = XW - 8;
    localparam int AW  = (XW > MOD_WIDTH) ? XW : MOD_WIDTH;
    localparam int LW  = $clog2(AW + 1);
    localparam int BCW = $clog2(CIPHER_BYTES);
    localparam int OCW = $clog2(CIPHER_BYTES + 1);

    // Key registers
    logic [MOD_WIDTH-1:0] modulus_reg;
    logic [MOD_WIDTH-1:0] pub_exp_reg;
    logic [MOD_WIDTH-1:0] priv_exp_reg;

    // Sequencer and datapath registers
    seq_state_t           state_reg, state_next;
    logic [PW-1:0]        partial_reg, partial_next;
    logic [BCW-1:0]       byte_count_reg, byte_count_next;
    logic                 func_reg, func_next;
    logic [MOD_WIDTH-1:0] acc_reg, acc_next;
    logic [MOD_WIDTH-1:0] sq_reg, sq_next;
    logic [MOD_WIDTH-1:0] k_reg, k_next;
    logic [XW-1:0]        shift_reg, shift_next;
    logic [OCW-1:0]       out_cnt_reg, out_cnt_next;

    // Multiplier interface
    logic                 mm_start;
    logic [AW-1:0]        mm_a;
    logic [MOD_WIDTH-1:0] mm_b;
    logic [LW-1:0]        mm_len;
    logic                 mm_busy;
    logic                 mm_done;
    logic [MOD_WIDTH-1:0] mm_result;

    logic                 item_accept;
    logic [XW-1:0]        operand;
    logic                 group_done;

    assign cfg_ready   = 1'b1;
    assign item_stall  = (state_reg != ST_IDLE);
    assign item_accept = item_valid && !item_stall;

    assign result_valid    = (state_reg == ST_EMIT);
    assign result.out_byte = shift_reg[XW-1:XW-8];
    assign result.last     = (out_cnt_reg == OCW'(1));

    assign group_done = (byte_count_reg == BCW'(CIPHER_BYTES - 1));
    assign operand    = (item.func == FUNC_ENCRYPT) ? XW'(item.data_byte)
                                                    : {partial_reg, item.data_byte};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg  <= MOD_WIDTH'(2);
            pub_exp_reg  <= MOD_WIDTH'(1);
            priv_exp_reg <= MOD_WIDTH'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MODULUS:     modulus_reg  <= MOD_WIDTH'(cfg_data);
                CFG_PUBLIC_EXP:  pub_exp_reg  <= MOD_WIDTH'(cfg_data);
                CFG_PRIVATE_EXP: priv_exp_reg <= MOD_WIDTH'(cfg_data);
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        partial_next    = partial_reg;
        byte_count_next = byte_count_reg;
        func_next       = func_reg;
        acc_next        = acc_reg;
        sq_next         = sq_reg;
        k_next          = k_reg;
        shift_next      = shift_reg;
        out_cnt_next    = out_cnt_reg;
        mm_start        = 1'b0;
        mm_a            = AW'(operand) << (AW - XW);
        mm_b            = MOD_WIDTH'(1);
        mm_len          = LW'(XW);

        case (state_reg)
            ST_IDLE:
            begin
                if (item_accept)
                begin
                    func_next = item.func;
                    if (item.func == FUNC_DECRYPT && !group_done)
                    begin
                        partial_next    = PW'({partial_reg, item.data_byte});
                        byte_count_next = byte_count_reg + BCW'(1);
                    end
                    else
                    begin
                        partial_next    = '0;
                        byte_count_next = '0;
                        if (modulus_reg == '0)
                        begin
                            // A zero modulus gives zero for every exponentiation.
                            acc_next   = '0;
                            k_next     = '0;
                            state_next = ST_NEXT;
                        end
                        else
                        begin
                            mm_start   = 1'b1;
                            state_next = ST_REDUCE;
                        end
                    end
                end
            end

            ST_REDUCE:
            begin
                if (mm_done)
                begin
                    sq_next    = mm_result;
                    // With a modulus of one the empty product is already zero.
                    acc_next   = (modulus_reg == MOD_WIDTH'(1)) ? '0 : MOD_WIDTH'(1);
                    k_next     = (func_reg == FUNC_DECRYPT) ? priv_exp_reg : pub_exp_reg;
                    state_next = ST_NEXT;
                end
            end

            ST_NEXT:
            begin
                mm_len = LW'(MOD_WIDTH);
                if (k_reg == '0)
                begin
                    if (func_reg == FUNC_DECRYPT)
                    begin
                        shift_next   = XW'(acc_reg[7:0]) << (XW - 8);
                        out_cnt_next = OCW'(1);
                    end
                    else
                    begin
                        shift_next   = XW'(acc_reg);
                        out_cnt_next = OCW'(CIPHER_BYTES);
                    end
                    state_next = ST_EMIT;
                end
                else if (k_reg[0])
                begin
                    mm_start   = 1'b1;
                    mm_a       = AW'(acc_reg) << (AW - MOD_WIDTH);
                    mm_b       = sq_reg;
                    state_next = ST_MUL_ACC;
                end
                else
                begin
                    mm_start   = 1'b1;
                    mm_a       = AW'(sq_reg) << (AW - MOD_WIDTH);
                    mm_b       = sq_reg;
                    state_next = ST_MUL_SQ;
                end
            end

            ST_MUL_ACC:
            begin
                mm_len = LW'(MOD_WIDTH);
                mm_a   = AW'(sq_reg) << (AW - MOD_WIDTH);
                mm_b   = sq_reg;
                if (mm_done)
                begin
                    acc_next = mm_result;
                    if ((k_reg >> 1) == '0)
                    begin
                        // Highest exponent bit done: the last square is not needed.
                        k_next     = '0;
                        state_next = ST_NEXT;
                    end
                    else
                    begin
                        mm_start   = 1'b1;
                        state_next = ST_MUL_SQ;
                    end
                end
            end

            ST_MUL_SQ:
            begin
                if (mm_done)
                begin
                    sq_next    = mm_result;
                    k_next     = k_reg >> 1;
                    state_next = ST_NEXT;
                end
            end

            ST_EMIT:
            begin
                if (!result_stall)
                begin
                    shift_next   = shift_reg << 8;
                    out_cnt_next = out_cnt_reg - OCW'(1);
                    if (out_cnt_reg == OCW'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            partial_reg    <= '0;
            byte_count_reg <= '0;
            out_cnt_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            partial_reg    <= partial_next;
            byte_count_reg <= byte_count_next;
            out_cnt_reg    <= out_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg  <= func_next;
        acc_reg   <= acc_next;
        sq_reg    <= sq_next;
        k_reg     <= k_next;
        shift_reg <= shift_next;
    end

    rsabc_modmul #(
        .MOD_WIDTH (MOD_WIDTH),
        .OPA_WIDTH (AW),
        .LEN_WIDTH (LW)
    ) u_modmul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mm_start),
        .op_a    (mm_a),
        .op_b    (mm_b),
        .op_len  (mm_len),
        .modulus (modulus_reg),
        .busy    (mm_busy),
        .done    (mm_done),
        .result  (mm_result)
    );

    // The multiplier only runs while the sequencer waits on it.
    assert property (@(posedge clk) disable iff (!rst_n)
        mm_busy |-> (state_reg == ST_REDUCE || state_reg == ST_MUL_ACC ||
                     state_reg == ST_MUL_SQ))
        else $error("multiplier busy outside a compute state");

    // Handing over the final byte of a request returns the block to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_stall && result.last) |=> (!result_valid && !item_stall))
        else $error("block not idle after last result byte");

    // A decrypt result is always a single byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) && func_reg == FUNC_DECRYPT |-> result.last)
        else $error("decrypt request produced more than one byte");

    // A start always leaves the multiplier busy on the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        mm_start |=> mm_busy)
        else $error("multiplier did not start");

endmodule

// ----- rtl/core/rsabc_modmul.sv -----
`timescale 1ns / 1ps
// Bit-serial modular multiplier: r = (a * b) mod n, one bit of a per cycle, MSB first.
// Depends on rsabc_pkg for the default modulus width.
module rsabc_modmul #(
    parameter int MOD_WIDTH = rsabc_pkg::MOD_WIDTH_DEF,
    parameter int OPA_WIDTH = 32,
    parameter int LEN_WIDTH = $clog2(OPA_WIDTH + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [OPA_WIDTH-1:0] op_a,
    input  logic [MOD_WIDTH-1:0] op_b,
    input  logic [LEN_WIDTH-1:0] op_len,
    input  logic [MOD_WIDTH-1:0] modulus,
    output logic                 busy,
    output logic                 done,
    output logic [MOD_WIDTH-1:0] result
);
    import rsabc_pkg::*;

    localparam int TW = MOD_WIDTH + 2;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [LEN_WIDTH-1:0] cnt_reg, cnt_next;
    logic [OPA_WIDTH-1:0] a_reg, a_next;
    logic [MOD_WIDTH-1:0] b_reg, b_next;
    logic [MOD_WIDTH-1:0] r_reg, r_next;

    logic [TW-1:0] t;
    logic [TW-1:0] n1;
    logic [TW-1:0] n2;
    logic [TW-1:0] t_red;

    // With r and b both below n, 2r + b stays below 3n, so at most 2n comes off.
    always_comb
    begin
        n1 = TW'(modulus);
        n2 = TW'(modulus) << 1;
        t  = (TW'(r_reg) << 1) + (a_reg[OPA_WIDTH-1] ? TW'(b_reg) : TW'(0));
        if (t >= n2)
        begin
            t_red = t - n2;
        end
        else if (t >= n1)
        begin
            t_red = t - n1;
        end
        else
        begin
            t_red = t;
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        r_next    = r_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = op_len;
            a_next    = op_a;
            b_next    = op_b;
            r_next    = '0;
        end
        else if (busy_reg)
        begin
            r_next   = t_red[MOD_WIDTH-1:0];
            a_next   = a_reg << 1;
            cnt_next = cnt_reg - LEN_WIDTH'(1);
            if (cnt_reg == LEN_WIDTH'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        r_reg <= r_next;
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = r_reg;

endmodule

// ----- dv/rsa_byte_cipher_modexp_top_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for rsa_byte_cipher_modexp_top: directed and random byte requests
// against a behavioural model of the cipher. Depends on rsabc_pkg and the RTL beneath the top.
module rsa_byte_cipher_modexp_top_tb;
    import rsabc_pkg::*;

    localparam int CLK_PERIOD     = 4;
    localparam int GROUP_BYTES    = CIPHER_BYTES_DEF;
    localparam int SETTLE_CYCLES  = 700;
    localparam int TIMEOUT_CYCLES = 2_000_000;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_SPARE = 2'd3;

    logic                     clk          = 1'b0;
    logic                     rst_n        = 1'b0;
    logic                     item_valid   = 1'b0;
    logic                     item_stall;
    in_item_t                 item         = '0;
    logic                     result_valid;
    logic                     result_stall = 1'b0;
    out_item_t                result;
    logic                     cfg_valid    = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_WIDTH-1:0] cfg_index    = '0;
    logic [CFG_WIDTH-1:0]     cfg_data     = '0;

    // Key registers and decrypt gathering state as the block should hold them.
    logic [15:0] key_modulus;
    logic [15:0] key_public;
    logic [15:0] key_private;
    logic [23:0] gathered_cipher;
    logic [1:0]  gathered_count;

    out_item_t   expected_bytes[$];
    int          mismatches  = 0;
    int          cycle_count = 0;
    bit          gaps_on     = 1'b1;

    rsa_byte_cipher_modexp_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == TIMEOUT_CYCLES)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Square-and-multiply over the exponent bits, least significant first.
    function automatic logic [15:0] mod_pow(logic [31:0] base, logic [15:0] expo,
                                            logic [15:0] n);
        logic [63:0] acc;
        logic [63:0] sq;
        logic [63:0] n64;
        logic [15:0] k;
        if (n == 16'd0)
            return 16'd0;
        n64 = {48'd0, n};
        acc = 64'd1;
        sq  = {32'd0, base} % n64;
        k   = expo;
        while (k != 16'd0)
        begin
            if (k[0])
                acc = (acc * sq) % n64;
            sq = (sq * sq) % n64;
            k  = k >> 1;
        end
        return 16'(acc % n64);
    endfunction

    task automatic predict_request(input in_item_t req);
        logic [31:0] value;
        out_item_t   rsp;
        if (req.func == FUNC_ENCRYPT)
        begin
            value = {16'd0, mod_pow({24'd0, req.data_byte}, key_public, key_modulus)};
            gathered_cipher = '0;
            gathered_count  = '0;
            for (int k = 0; k < GROUP_BYTES; k++)
            begin
                rsp.out_byte = 8'(value >> (8 * (GROUP_BYTES - 1 - k)));
                rsp.last     = (k == GROUP_BYTES - 1);
                expected_bytes = {expected_bytes, rsp};
            end
        end
        else if (int'(gathered_count) + 1 < GROUP_BYTES)
        begin
            gathered_cipher = {gathered_cipher[15:0], req.data_byte};
            gathered_count  = gathered_count + 2'd1;
        end
        else
        begin
            value = {gathered_cipher, req.data_byte};
            rsp.out_byte = 8'(mod_pow(value, key_private, key_modulus));
            rsp.last     = 1'b1;
            gathered_cipher = '0;
            gathered_count  = '0;
            expected_bytes = {expected_bytes, rsp};
        end
    endtask

    task automatic send_request(input logic func, input logic [7:0] value);
        in_item_t req;
        req.func      = func;
        req.data_byte = value;
        if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        item       <= req;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (item_stall);
        predict_request(req);
    endtask

    task automatic send_group(input logic [31:0] cipher);
        for (int k = GROUP_BYTES - 1; k >= 0; k--)
            send_request(FUNC_DECRYPT, cipher[8 * k +: 8]);
    endtask

    // Drops valid and waits until every expected byte is out and the block is quiet.
    task automatic settle();
        item_valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_key(input logic [CFG_IDX_WIDTH-1:0] index,
                             input logic [CFG_WIDTH-1:0] value);
        cfg_index <= index;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (index)
            CFG_MODULUS:     key_modulus = value;
            CFG_PUBLIC_EXP:  key_public  = value;
            CFG_PRIVATE_EXP: key_private = value;
            default:         ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_keys(input logic [15:0] n, input logic [15:0] e, input logic [15:0] d);
        settle();
        write_key(CFG_MODULUS, n);
        write_key(CFG_PUBLIC_EXP, e);
        write_key(CFG_PRIVATE_EXP, d);
    endtask

    always
    begin
        @(posedge clk);
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            result_stall <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            result_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_bytes.size() == 0)
            begin
                $error("unexpected result: out_byte %0h last %0b", result.out_byte, result.last);
                mismatches++;
            end
            else
            begin
                if (result.out_byte !== expected_bytes[0].out_byte)
                begin
                    $error("out_byte mismatch: expected %0h, got %0h",
                           expected_bytes[0].out_byte, result.out_byte);
                    mismatches++;
                end
                if (result.last !== expected_bytes[0].last)
                begin
                    $error("last mismatch: expected %0b, got %0b",
                           expected_bytes[0].last, result.last);
                    mismatches++;
                end
                void'(expected_bytes.pop_front());
            end
        end
    end

    // Keys as they come out of reset.
    task automatic test_reset_keys();
        send_request(FUNC_ENCRYPT, 8'hA5);
        send_group(32'h0000_0001);
    endtask

    task automatic test_field_extremes();
        load_keys(16'd3233, 16'd17, 16'd2753);
        send_request(FUNC_ENCRYPT, 8'h00);
        send_request(FUNC_ENCRYPT, 8'hFF);
        // The gathered ciphertext lies far above the modulus and the result above 255.
        send_group(32'hFFFF_FFFF);
        // A partial group is thrown away by the encryption request that follows.
        send_request(FUNC_DECRYPT, 8'h12);
        send_request(FUNC_DECRYPT, 8'h34);
        send_request(FUNC_ENCRYPT, 8'h7E);
        send_group(32'h0000_0BE5);
    endtask

    task automatic test_key_corners();
        load_keys(16'd0, 16'd5, 16'd7);
        send_request(FUNC_ENCRYPT, 8'hC3);
        settle();
        write_key(CFG_MODULUS, 16'd1);
        send_request(FUNC_ENCRYPT, 8'h3C);
        // Zero exponents give one whatever the base.
        load_keys(16'd3233, 16'd0, 16'd0);
        send_request(FUNC_ENCRYPT, 8'h99);
        send_group(32'h0000_0100);
        load_keys(16'hFFFF, 16'hFFFF, 16'hFFFF);
        settle();
        write_key(CFG_SPARE, 16'h1234);
        send_request(FUNC_ENCRYPT, 8'hFE);
        send_group(32'hFFFF_FFFE);
    endtask

    task automatic run_traffic(input int unsigned count);
        int unsigned sent;
        int unsigned pick;
        int unsigned stray;
        logic [7:0]  plain;
        logic [15:0] cipher;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 4)
            begin
                // Round trip: encrypt a byte, then feed its ciphertext back as a group.
                plain  = 8'($urandom_range(0, 255));
                cipher = mod_pow({24'd0, plain}, key_public, key_modulus);
                send_request(FUNC_ENCRYPT, plain);
                send_group({16'd0, cipher});
                sent += 5;
            end
            else if (pick < 7)
            begin
                send_group($urandom);
                sent += 4;
            end
            else if (pick < 9)
            begin
                send_request(FUNC_ENCRYPT, 8'($urandom_range(0, 255)));
                sent += 1;
            end
            else
            begin
                stray = $urandom_range(1, 3);
                repeat (stray) send_request(FUNC_DECRYPT, 8'($urandom_range(0, 255)));
                sent += stray;
            end
        end
    endtask

    task automatic test_random_traffic();
        load_keys(16'd3233, 16'd17, 16'd2753);
        run_traffic(72);
        load_keys(16'd143, 16'd7, 16'd103);
        run_traffic(72);
        load_keys(16'd64507, 16'd3, 16'd42667);
        run_traffic(72);
        load_keys(16'($urandom_range(2, 65535)), 16'($urandom), 16'($urandom));
        run_traffic(72);
        load_keys(16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_traffic(71);
        load_keys(16'($urandom_range(2, 65535)), 16'($urandom), 16'($urandom));
        gaps_on = 1'b0;
        run_traffic(71);
    endtask

    initial
    begin
        key_modulus     = 16'd2;
        key_public      = 16'd1;
        key_private     = 16'd1;
        gathered_cipher = '0;
        gathered_count  = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_keys();
        test_field_extremes();
        test_key_corners();
        test_random_traffic();
        settle();

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
